>>> rtl/rmh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rmh_pkg;

    localparam int DEF_MAX_ITEMS  = 1024;
    localparam int DEF_VALUE_BITS = 32;

    typedef enum logic [1:0] {
        HOP_CLEAR,
        HOP_PUSH,
        HOP_POP
    } heap_op_t;

    typedef struct packed {
        logic     start;
        heap_op_t op;
    } heap_cmd_t;

    typedef enum logic [1:0] {
        H_IDLE,
        H_UP,
        H_LAST,
        H_DOWN
    } heap_state_t;

    typedef enum logic [2:0] {
        C_IDLE,
        C_DECIDE,
        C_ISSUE,
        C_WAIT,
        C_FINISH
    } ctrl_state_t;

endpackage
`default_nettype wire

>>> rtl/running_median_two_heaps_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: an accepted word is checked against the capacity; a refused word answers with
// the current figures, any other runs up to three heap steps: a push sifts up level by level
// (an empty heap takes it at the root), a pop moves the last item to the root and sifts down.
// Flow: one word in flight; the next is taken the cycle after the result is popped,
// so the sift walks of the heap memories set the rate.
// Reset: asynchronous, active low; empties both heaps and zeroes the stored median.
module running_median_two_heaps_core import rmh_pkg::*; #(
    parameter int MAX_ITEMS  = DEF_MAX_ITEMS,
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic                         restart,
    input  wire logic signed [VALUE_BITS-1:0] sample,
    output logic                              empty,
    input  wire logic                         pop,
    output logic signed [VALUE_BITS-1:0]      median_value,
    output logic [CNT_W-1:0]                  held_count,
    output logic                              full_res
);

    localparam int DEPTH = (MAX_ITEMS + 1) / 2;
    localparam int SW    = $clog2(DEPTH + 1);

    logic                         q_valid, q_take, q_restart;
    logic signed [VALUE_BITS-1:0] q_sample, hval, ltop, utop;
    heap_cmd_t                    lcmd, ucmd;
    logic                         lbusy, ubusy;
    logic [SW-1:0]                lsize, usize;

    rmh_front #(.VALUE_BITS(VALUE_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .restart(restart), .sample(sample),
        .q_valid(q_valid), .q_take(q_take), .q_restart(q_restart), .q_sample(q_sample)
    );

    rmh_heap #(.DEPTH(DEPTH), .VALUE_BITS(VALUE_BITS), .IS_MAX(1'b1)) u_lower (
        .clk(clk), .rst_n(rst_n), .cmd(lcmd), .value(hval),
        .busy(lbusy), .top(ltop), .size(lsize)
    );

    rmh_heap #(.DEPTH(DEPTH), .VALUE_BITS(VALUE_BITS), .IS_MAX(1'b0)) u_upper (
        .clk(clk), .rst_n(rst_n), .cmd(ucmd), .value(hval),
        .busy(ubusy), .top(utop), .size(usize)
    );

    rmh_ctrl #(.MAX_ITEMS(MAX_ITEMS), .VALUE_BITS(VALUE_BITS)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_take(q_take), .q_restart(q_restart), .q_sample(q_sample),
        .lcmd(lcmd), .ucmd(ucmd), .hval(hval),
        .lbusy(lbusy), .ubusy(ubusy), .ltop(ltop), .utop(utop),
        .lsize(lsize), .usize(usize),
        .empty(empty), .pop(pop),
        .median_value(median_value), .held_count(held_count), .full_res(full_res)
    );

endmodule
`default_nettype wire

>>> rtl/rmh_front.sv
`timescale 1ns / 1ps
`default_nettype none
module rmh_front import rmh_pkg::*; #(
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic                         restart,
    input  wire logic signed [VALUE_BITS-1:0] sample,
    output logic                              q_valid,
    input  wire logic                         q_take,
    output logic                              q_restart,
    output logic signed [VALUE_BITS-1:0]      q_sample
);

    // two-word queue between the port and the sequencer
    logic                         rst_mem_reg [2];
    logic signed [VALUE_BITS-1:0] smp_mem_reg [2];
    logic                         wptr_reg, wptr_next;
    logic                         rptr_reg, rptr_next;
    logic [1:0]                   cnt_reg, cnt_next;
    logic                         wr, rd;

    assign full      = (cnt_reg == 2'd2);
    assign q_valid   = (cnt_reg != 2'd0);
    assign q_restart = rst_mem_reg[rptr_reg];
    assign q_sample  = smp_mem_reg[rptr_reg];
    assign wr        = push && !full;
    assign rd        = q_take && q_valid;

    always_comb
    begin
        wptr_next = wptr_reg ^ wr;
        rptr_next = rptr_reg ^ rd;
        cnt_next  = cnt_reg + {1'b0, wr} - {1'b0, rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            rst_mem_reg[wptr_reg] <= restart;
            smp_mem_reg[wptr_reg] <= sample;
        end
    end

endmodule
`default_nettype wire

>>> rtl/rmh_heap.sv
`timescale 1ns / 1ps
`default_nettype none
module rmh_heap import rmh_pkg::*; #(
    parameter int DEPTH      = DEF_MAX_ITEMS / 2,
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter bit IS_MAX     = 1'b1,
    localparam int SW        = $clog2(DEPTH + 1)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire heap_cmd_t                    cmd,
    input  wire logic signed [VALUE_BITS-1:0] value,
    output logic                              busy,
    output logic signed [VALUE_BITS-1:0]      top,
    output logic [SW-1:0]                     size
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = AW + 2;

    logic signed [VALUE_BITS-1:0] mem [DEPTH];
    heap_state_t                  state_reg, state_next;
    logic [SW-1:0]                size_reg, size_next;
    logic [AW-1:0]                idx_reg, idx_next;
    logic signed [VALUE_BITS-1:0] val_reg, val_next;
    logic signed [VALUE_BITS-1:0] top_reg;
    logic signed [VALUE_BITS-1:0] rd0_reg, rd1_reg;
    logic [AW-1:0]                ra0, ra1, waddr;
    logic                         we;
    logic signed [VALUE_BITS-1:0] wdata;
    logic [CW-1:0]                lch, rch, nch;
    logic                         lv, rv;
    logic [1:0]                   bsel;
    logic signed [VALUE_BITS-1:0] bval;
    logic [AW-1:0]                nidx;
    logic [SW-1:0]                last;

    function automatic logic above(input logic signed [VALUE_BITS-1:0] a,
                                   input logic signed [VALUE_BITS-1:0] b);
        return IS_MAX ? (a > b) : (a < b);
    endfunction

    function automatic logic [AW-1:0] parent(input logic [AW-1:0] i);
        logic [AW-1:0] d;
        d = i - 1'b1;
        return d >> 1;
    endfunction

    assign busy = (state_reg != H_IDLE);
    assign top  = top_reg;
    assign size = size_reg;

    always_comb
    begin
        state_next = state_reg;
        size_next  = size_reg;
        idx_next   = idx_reg;
        val_next   = val_reg;
        we         = 1'b0;
        waddr      = idx_reg;
        wdata      = val_reg;
        ra0        = parent(idx_reg);
        ra1        = '0;
        last       = size_reg - 1'b1;
        lch        = {1'b0, idx_reg, 1'b1};
        rch        = lch + 1'b1;
        lv         = lch < CW'(size_reg);
        rv         = rch < CW'(size_reg);
        bsel       = 2'd0;
        bval       = val_reg;
        nidx       = '0;
        nch        = '0;
        unique case (state_reg)
            H_IDLE:
            begin
                if (cmd.start)
                begin
                    unique case (cmd.op)
                        HOP_CLEAR:
                            size_next = '0;
                        HOP_PUSH:
                        begin
                            if (size_reg < SW'(DEPTH))
                            begin
                                size_next = size_reg + 1'b1;
                                val_next  = value;
                                if (size_reg == '0)
                                begin
                                    we    = 1'b1;
                                    waddr = '0;
                                    wdata = value;
                                end
                                else
                                begin
                                    idx_next   = size_reg[AW-1:0];
                                    ra0        = parent(size_reg[AW-1:0]);
                                    state_next = H_UP;
                                end
                            end
                        end
                        HOP_POP:
                        begin
                            if (size_reg != '0)
                            begin
                                size_next = last;
                                if (last != '0)
                                begin
                                    ra0        = last[AW-1:0];
                                    state_next = H_LAST;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            H_UP:
            begin
                // hole walks up; rd0 holds the parent of idx
                we = 1'b1;
                if (idx_reg != '0 && above(val_reg, rd0_reg))
                begin
                    wdata    = rd0_reg;
                    idx_next = parent(idx_reg);
                    ra0      = parent(parent(idx_reg));
                end
                else
                begin
                    state_next = H_IDLE;
                end
            end
            H_LAST:
            begin
                val_next   = rd0_reg;
                idx_next   = '0;
                ra0        = AW'(1);
                ra1        = AW'(2);
                state_next = H_DOWN;
            end
            H_DOWN:
            begin
                if (lv && above(rd0_reg, bval))
                begin
                    bsel = 2'd1;
                    bval = rd0_reg;
                end
                if (rv && above(rd1_reg, bval))
                begin
                    bsel = 2'd2;
                    bval = rd1_reg;
                end
                we    = 1'b1;
                wdata = bval;
                if (bsel == 2'd0)
                begin
                    state_next = H_IDLE;
                end
                else
                begin
                    nidx     = (bsel == 2'd1) ? lch[AW-1:0] : rch[AW-1:0];
                    idx_next = nidx;
                    nch      = {1'b0, nidx, 1'b1};
                    ra0      = nch[AW-1:0];
                    ra1      = AW'(nch + 1'b1);
                end
            end
            default: state_next = H_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            size_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            size_reg  <= size_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        val_reg <= val_next;
        rd0_reg <= mem[ra0];
        rd1_reg <= mem[ra1];
        if (we)
        begin
            mem[waddr] <= wdata;
            if (waddr == '0)
                top_reg <= wdata;
        end
    end

    a_size_cap: assert property (@(posedge clk) disable iff (!rst_n)
        size_reg <= SW'(DEPTH))
        else $error("heap size beyond depth");
    a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == H_DOWN) |-> (size_reg != '0))
        else $error("sift-down on empty heap");
    a_cmd_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> (state_reg == H_IDLE))
        else $error("command while walking");

endmodule
`default_nettype wire

>>> rtl/rmh_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module rmh_ctrl import rmh_pkg::*; #(
    parameter int MAX_ITEMS  = DEF_MAX_ITEMS,
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    localparam int SW        = $clog2((MAX_ITEMS + 1) / 2 + 1),
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         q_valid,
    output logic                              q_take,
    input  wire logic                         q_restart,
    input  wire logic signed [VALUE_BITS-1:0] q_sample,
    output heap_cmd_t                         lcmd,
    output heap_cmd_t                         ucmd,
    output logic signed [VALUE_BITS-1:0]      hval,
    input  wire logic                         lbusy,
    input  wire logic                         ubusy,
    input  wire logic signed [VALUE_BITS-1:0] ltop,
    input  wire logic signed [VALUE_BITS-1:0] utop,
    input  wire logic [SW-1:0]                lsize,
    input  wire logic [SW-1:0]                usize,
    output logic                              empty,
    input  wire logic                         pop,
    output logic signed [VALUE_BITS-1:0]      median_value,
    output logic [CNT_W-1:0]                  held_count,
    output logic                              full_res
);

    ctrl_state_t                  state_reg, state_next;
    logic signed [VALUE_BITS-1:0] x_reg, x_next;
    logic signed [VALUE_BITS-1:0] med_reg, med_next;
    logic [1:0]                   nsteps_reg, nsteps_next;
    logic [1:0]                   step_reg, step_next;
    logic [2:0]                   sel_reg, sel_next;    // 1: upper heap
    logic [2:0]                   pop_reg, pop_next;    // 1: pop, else push
    logic [2:0]                   usex_reg, usex_next;  // 1: push x, else other top
    logic                         avg_reg, avg_next;
    logic                         ovalid_reg, ovalid_next;
    logic signed [VALUE_BITS-1:0] omed_reg, omed_next;
    logic [CNT_W-1:0]             ocnt_reg, ocnt_next;
    logic                         ofull_reg, ofull_next;
    logic [CNT_W-1:0]             total;
    logic                         gt;
    logic signed [VALUE_BITS:0]   sum;
    logic signed [VALUE_BITS:0]   half;
    heap_cmd_t                    cmd;

    assign empty        = !ovalid_reg;
    assign median_value = omed_reg;
    assign held_count   = ocnt_reg;
    assign full_res     = ofull_reg;

    always_comb
    begin
        total       = CNT_W'(lsize) + CNT_W'(usize);
        gt          = x_reg > med_reg;
        sum         = {ltop[VALUE_BITS-1], ltop} + {utop[VALUE_BITS-1], utop};
        half        = (sum + {{VALUE_BITS{1'b0}}, sum[VALUE_BITS]}) >>> 1;
        state_next  = state_reg;
        x_next      = x_reg;
        med_next    = med_reg;
        nsteps_next = nsteps_reg;
        step_next   = step_reg;
        sel_next    = sel_reg;
        pop_next    = pop_reg;
        usex_next   = usex_reg;
        avg_next    = avg_reg;
        ovalid_next = ovalid_reg && !pop;
        omed_next   = omed_reg;
        ocnt_next   = ocnt_reg;
        ofull_next  = ofull_reg;
        q_take      = 1'b0;
        cmd         = '{start: 1'b0, op: HOP_CLEAR};
        lcmd        = cmd;
        ucmd        = cmd;
        hval        = usex_reg[step_reg] ? x_reg : (sel_reg[step_reg] ? ltop : utop);
        unique case (state_reg)
            C_IDLE:
            begin
                if (q_valid && !ovalid_reg)
                begin
                    q_take = 1'b1;
                    x_next = q_sample;
                    if (q_restart)
                    begin
                        lcmd     = '{start: 1'b1, op: HOP_CLEAR};
                        ucmd     = '{start: 1'b1, op: HOP_CLEAR};
                        med_next = '0;
                    end
                    state_next = C_DECIDE;
                end
            end
            C_DECIDE:
            begin
                step_next = 2'd0;
                avg_next  = (lsize != usize);
                if (total >= CNT_W'(MAX_ITEMS))
                begin
                    // refuse: state kept, word reports current figures
                    ovalid_next = 1'b1;
                    omed_next   = med_reg;
                    ocnt_next   = total;
                    ofull_next  = 1'b1;
                    state_next  = C_IDLE;
                end
                else
                begin
                    state_next = C_ISSUE;
                    if (lsize == usize)
                    begin
                        nsteps_next = 2'd1;
                        sel_next    = {2'b00, gt};
                        pop_next    = 3'b000;
                        usex_next   = 3'b001;
                    end
                    else if ((lsize > usize) == gt)
                    begin
                        nsteps_next = 2'd1;
                        sel_next    = {2'b00, gt};
                        pop_next    = 3'b000;
                        usex_next   = 3'b001;
                    end
                    else
                    begin
                        // move the bigger side's top across, then add x there
                        nsteps_next = 2'd3;
                        sel_next    = gt ? 3'b110 : 3'b001;
                        pop_next    = 3'b010;
                        usex_next   = 3'b100;
                    end
                end
            end
            C_ISSUE:
            begin
                cmd = '{start: 1'b1, op: pop_reg[step_reg] ? HOP_POP : HOP_PUSH};
                if (sel_reg[step_reg])
                    ucmd = cmd;
                else
                    lcmd = cmd;
                state_next = C_WAIT;
            end
            C_WAIT:
            begin
                if (!lbusy && !ubusy)
                begin
                    step_next  = step_reg + 1'b1;
                    state_next = (step_reg + 1'b1 == nsteps_reg) ? C_FINISH : C_ISSUE;
                end
            end
            C_FINISH:
            begin
                if (avg_reg)
                    med_next = half[VALUE_BITS-1:0];
                else
                    med_next = sel_reg[0] ? utop : ltop;
                ovalid_next = 1'b1;
                omed_next   = med_next;
                ocnt_next   = total;
                ofull_next  = 1'b0;
                state_next  = C_IDLE;
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= C_IDLE;
            med_reg    <= '0;
            ovalid_reg <= 1'b0;
            step_reg   <= 2'd0;
            nsteps_reg <= 2'd1;
        end
        else
        begin
            state_reg  <= state_next;
            med_reg    <= med_next;
            ovalid_reg <= ovalid_next;
            step_reg   <= step_next;
            nsteps_reg <= nsteps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        sel_reg  <= sel_next;
        pop_reg  <= pop_next;
        usex_reg <= usex_next;
        avg_reg  <= avg_next;
        omed_reg <= omed_next;
        ocnt_reg <= ocnt_next;
        ofull_reg <= ofull_next;
    end

    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W'(lsize) + CNT_W'(usize)) <= CNT_W'(MAX_ITEMS))
        else $error("held count beyond capacity");
    a_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == C_DECIDE) |->
            (CNT_W'(lsize) <= CNT_W'(usize) + 1'b1 && CNT_W'(usize) <= CNT_W'(lsize) + 1'b1))
        else $error("heaps out of balance");
    a_refuse: assert property (@(posedge clk) disable iff (!rst_n)
        (!ovalid_reg && ovalid_next && ofull_next) |=> (ocnt_reg == CNT_W'(MAX_ITEMS)))
        else $error("refusal below capacity");

endmodule
`default_nettype wire
